/* design/periodic_k_nearest_neighbors_assert.svh */
// Assertion macros for the neighbor search block.
`ifndef PERIODIC_K_NEAREST_NEIGHBORS_ASSERT_SVH
`define PERIODIC_K_NEAREST_NEIGHBORS_ASSERT_SVH
`ifndef SYNTHESIS
`define PKNN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PKNN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PKNN_ASSERT(label, clk, rst_n, prop, msg)
`define PKNN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/pknn_pkg.sv */
`timescale 1ns / 1ps
package pknn_pkg;
  localparam int MaxParticles = 1024;
  localparam int Neighbors    = 12;
  localparam int PosBits      = 24;
  localparam int IdxBits      = $clog2(MaxParticles);
  localparam int CntBits      = IdxBits + 1;
  localparam int SlotBits     = 4;
  localparam int HalfBits     = 23;
  localparam int DiffBits     = PosBits + 3;
  localparam int DistBits     = 46;
  localparam int SqBits       = 2 * DiffBits;
  localparam int SumBits      = SqBits + 2;

  localparam logic [2:0] RegCount  = 3'd0;
  localparam logic [2:0] RegHalfX  = 3'd1;
  localparam logic [2:0] RegHalfY  = 3'd2;
  localparam logic [2:0] RegHalfZ  = 3'd3;
  localparam logic [2:0] RegCutoff = 3'd4;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Offer of one candidate to the sorted list.
  typedef struct packed {
    logic                valid;
    logic [IdxBits-1:0]  index;
    logic [DistBits-1:0] sq_dist;
  } cand_t;

  typedef struct packed {
    logic [HalfBits-1:0] half_x;
    logic [HalfBits-1:0] half_y;
    logic [HalfBits-1:0] half_z;
  } halves_t;

  function automatic logic signed [PosBits-1:0] clamp_pos(
      input logic signed [PosBits-1:0] p, input logic [HalfBits-1:0] h);
    logic signed [PosBits:0] pe;
    logic signed [PosBits:0] he;
    pe = {p[PosBits-1], p};
    he = $signed({{(PosBits+1-HalfBits){1'b0}}, h});
    if (pe > he) clamp_pos = he[PosBits-1:0];
    else if (pe < -he) clamp_pos = PosBits'(-he);
    else clamp_pos = p;
  endfunction
endpackage

/* design/pknn_dist.sv */
`timescale 1ns / 1ps
// Axis unit shared over x, y and z: one axis each cycle while enabled, accumulating the sum.
module pknn_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  axis_i,
  input  logic signed [pknn_pkg::PosBits-1:0] a_i,
  input  logic signed [pknn_pkg::PosBits-1:0] b_i,
  input  logic [pknn_pkg::HalfBits-1:0] h_i,
  input  logic                        en_i,
  output logic [pknn_pkg::DistBits-1:0] dist_o
);
  import pknn_pkg::*;
  logic signed [DiffBits-1:0] d, dw, he;
  logic [DiffBits-1:0] u;
  logic [SqBits-1:0] sq;
  logic [SumBits-1:0] acc_q, acc_d, base;

  always_comb begin
    he = $signed({{(DiffBits-HalfBits){1'b0}}, h_i});
    d  = DiffBits'(b_i) - DiffBits'(a_i);
    if (d > he) dw = d - (he <<< 1);
    else if (d < -he) dw = d + (he <<< 1);
    else dw = d;
    u  = dw[DiffBits-1] ? DiffBits'(-dw) : DiffBits'(dw);
    sq = SqBits'(u) * SqBits'(u);
    base = (axis_i == 2'd0) ? '0 : acc_q;
    acc_d = base + SumBits'(sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else if (start_i) acc_q <= '0;
    else if (en_i) acc_q <= acc_d;
  end

  assign dist_o = (|acc_q[SumBits-1:DistBits]) ? '1 : acc_q[DistBits-1:0];
endmodule

/* design/pknn_list.sv */
`timescale 1ns / 1ps
// Sorted list of nearest candidates with strict insertion.
module pknn_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [pknn_pkg::DistBits-1:0] cutoff_i,
  input  pknn_pkg::cand_t               cand_i,
  input  logic [pknn_pkg::SlotBits-1:0] rd_slot_i,
  output logic [pknn_pkg::IdxBits-1:0]  rd_index_o,
  output logic [pknn_pkg::DistBits-1:0] rd_dist_o,
  output logic                          rd_found_o
);
  import pknn_pkg::*;
  logic [IdxBits-1:0]  idx_q [Neighbors];
  logic [DistBits-1:0] dst_q [Neighbors];
  logic [Neighbors-1:0] full_q;
  logic [Neighbors-1:0] lt;

  always_comb begin
    for (int k = 0; k < Neighbors; k++) lt[k] = cand_i.sq_dist < dst_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= '0;
    else if (clear_i) full_q <= '0;
    else if (cand_i.valid && lt[Neighbors-1]) full_q <= {full_q[Neighbors-2:0], 1'b1};
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      for (int k = 0; k < Neighbors; k++) begin
        idx_q[k] <= '0;
        dst_q[k] <= cutoff_i;
      end
    end else if (cand_i.valid) begin
      for (int k = 0; k < Neighbors; k++) begin
        if (lt[k]) begin
          if (k == 0 || !lt[(k == 0) ? 0 : k-1]) begin
            idx_q[k] <= cand_i.index;
            dst_q[k] <= cand_i.sq_dist;
          end else begin
            idx_q[k] <= idx_q[(k == 0) ? 0 : k-1];
            dst_q[k] <= dst_q[(k == 0) ? 0 : k-1];
          end
        end
      end
    end
  end

  always_comb begin
    rd_index_o = '0;
    rd_dist_o  = cutoff_i;
    rd_found_o = 1'b0;
    for (int k = 0; k < Neighbors; k++) begin
      if (rd_slot_i == SlotBits'(k) && full_q[k]) begin
        rd_index_o = idx_q[k];
        rd_dist_o  = dst_q[k];
        rd_found_o = 1'b1;
      end
    end
  end
endmodule

/* design/periodic_k_nearest_neighbors.sv */
`timescale 1ns / 1ps
// Periodic k-nearest-neighbor search. A load transaction (opcode 0) clamps a
// position into the box and writes it to three coordinate memories;
// a load position must be written before any query reads it. A query
// transaction (opcode 1) reads the queried particle, then scans every index
// below particle_count through one shared axis unit that handles x, y and z in
// turn, so each candidate takes a memory read plus three axis steps, and
// the 12 results of a query stream out after the scan, one per cycle while
// the receiver is ready, with tlast on the twelfth. The block is not ready
// while a transaction is in progress.
// Configuration may only be written while the block is idle.
module periodic_k_nearest_neighbors (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [45:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // tdata: particle[9:0], pos_x[33:10], pos_y[57:34], pos_z[81:58], zero fill
  input  logic [87:0]  s_tdata_i,
  // tuser: opcode
  input  logic         s_tuser_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // tdata: slot[3:0], neighbor[13:4], dist_squared[59:14], found[60], zero fill
  output logic [63:0]  m_tdata_o,
  output logic         m_tlast_o
);
  import pknn_pkg::*;
  `include "periodic_k_nearest_neighbors_assert.svh"

  localparam logic [2:0] StIdle = 3'd0, StLoad = 3'd1, StSelf = 3'd2,
                         StRead = 3'd3, StAxis = 3'd4, StOut = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CntBits-1:0] count_q;
  halves_t halves_q;
  logic [DistBits-1:0] cutoff_q;

  logic [PosBits-1:0] mem_x [MaxParticles];
  logic [PosBits-1:0] mem_y [MaxParticles];
  logic [PosBits-1:0] mem_z [MaxParticles];

  logic [IdxBits-1:0] who_q;
  logic [PosBits-1:0] wx_q, wy_q, wz_q;
  logic [PosBits-1:0] sx_q, sy_q, sz_q;
  logic [PosBits-1:0] ox_q, oy_q, oz_q;
  logic [CntBits-1:0] j_q, jr_q;
  logic [1:0] axis_q;
  logic [SlotBits-1:0] slot_q;
  logic self_pend_q;

  logic [CntBits-1:0] limit;
  assign limit = (count_q > CntBits'(MaxParticles)) ? CntBits'(MaxParticles) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CntBits'(1024);
      halves_q <= '{half_x: HalfBits'(40960), half_y: HalfBits'(40960),
                    half_z: HalfBits'(40960)};
      cutoff_q <= DistBits'(64'd164433494016);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCount:  count_q <= cfg_data_i[CntBits-1:0];
        RegHalfX:  halves_q.half_x <= cfg_data_i[HalfBits-1:0];
        RegHalfY:  halves_q.half_y <= cfg_data_i[HalfBits-1:0];
        RegHalfZ:  halves_q.half_z <= cfg_data_i[HalfBits-1:0];
        RegCutoff: cutoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic accept;
  assign s_tready_o = (state_q == StIdle);
  assign accept = s_tvalid_i && s_tready_o;

  // Memory write and registered reads. The read data is held while the axis
  // unit works through one candidate.
  logic [IdxBits-1:0] rd_addr;
  assign rd_addr = (state_q == StSelf) ? who_q : j_q[IdxBits-1:0];
  always_ff @(posedge clk_i) begin
    if (state_q == StLoad) begin
      mem_x[who_q] <= wx_q;
      mem_y[who_q] <= wy_q;
      mem_z[who_q] <= wz_q;
    end
    if (state_q == StSelf || state_q == StRead) begin
      ox_q <= mem_x[rd_addr];
      oy_q <= mem_y[rd_addr];
      oz_q <= mem_z[rd_addr];
    end
  end

  logic [DistBits-1:0] cand_dist;
  logic signed [PosBits-1:0] da, db;
  logic [HalfBits-1:0] dh;
  always_comb begin
    unique case (axis_q)
      2'd0: begin da = sx_q; db = ox_q; dh = halves_q.half_x; end
      2'd1: begin da = sy_q; db = oy_q; dh = halves_q.half_y; end
      default: begin da = sz_q; db = oz_q; dh = halves_q.half_z; end
    endcase
  end

  pknn_dist u_dist (
    .clk_i, .rst_ni, .start_i(1'b0), .axis_i(axis_q), .a_i(da), .b_i(db),
    .h_i(dh), .en_i(state_q == StAxis), .dist_o(cand_dist)
  );

  cand_t cand;
  logic [IdxBits-1:0] rd_index;
  logic [DistBits-1:0] rd_dist;
  logic rd_found;
  // A candidate is offered once its third axis has been summed.
  assign cand.valid = self_pend_q && (state_q != StOut || slot_q == '0) &&
                      (state_q == StRead || state_q == StOut) && (jr_q != CntBits'(who_q));
  assign cand.index = jr_q[IdxBits-1:0];
  assign cand.sq_dist = cand_dist;

  pknn_list u_list (
    .clk_i, .rst_ni, .clear_i(accept && s_tuser_i == OpQuery), .cutoff_i(cutoff_q),
    .cand_i(cand), .rd_slot_i(slot_q), .rd_index_o(rd_index), .rd_dist_o(rd_dist),
    .rd_found_o(rd_found)
  );

  logic out_ok;
  assign out_ok = (state_q == StOut) && !self_pend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = (s_tuser_i == OpQuery) ? StSelf : StLoad;
      StLoad: state_d = StIdle;
      StSelf: state_d = (limit == '0) ? StOut : StRead;
      StRead: state_d = StAxis;
      StAxis: if (axis_q == 2'd2) state_d = (j_q == limit) ? StOut : StRead;
      StOut:  if (out_ok && m_tready_i && slot_q == SlotBits'(Neighbors-1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      j_q <= '0; jr_q <= '0; axis_q <= '0; slot_q <= '0; self_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: begin j_q <= '0; slot_q <= '0; self_pend_q <= 1'b0; end
        StRead: begin
          if (self_pend_q) self_pend_q <= 1'b0;
          jr_q <= j_q; j_q <= j_q + 1'b1; axis_q <= 2'd0;
        end
        StAxis: begin
          axis_q <= axis_q + 1'b1;
          if (axis_q == 2'd2) self_pend_q <= 1'b1;
        end
        StOut: begin
          if (self_pend_q) self_pend_q <= 1'b0;
          else if (m_tready_i) slot_q <= slot_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Self coordinates are captured from the registered read of the queried index.
  logic self_cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) self_cap_q <= 1'b0;
    else self_cap_q <= (state_q == StSelf);
  end
  always_ff @(posedge clk_i) begin
    if (self_cap_q) begin sx_q <= ox_q; sy_q <= oy_q; sz_q <= oz_q; end
    if (accept) begin
      who_q <= s_tdata_i[IdxBits-1:0];
      wx_q <= clamp_pos(s_tdata_i[33:10], halves_q.half_x);
      wy_q <= clamp_pos(s_tdata_i[57:34], halves_q.half_y);
      wz_q <= clamp_pos(s_tdata_i[81:58], halves_q.half_z);
    end
  end

  assign m_tvalid_o = out_ok;
  assign m_tlast_o  = out_ok && (slot_q == SlotBits'(Neighbors-1));
  assign m_tdata_o  = {3'b0, rd_found, rd_dist, rd_index, slot_q};

  `PKNN_ASSERT(a_no_ready_busy, clk_i, rst_ni, !(s_tready_o && m_tvalid_o), "ready while output busy")
  `PKNN_ASSERT(a_last_slot, clk_i, rst_ni, !m_tlast_o || slot_q == SlotBits'(Neighbors-1), "tlast off slot")
  `PKNN_ASSERT_NEXT(a_load_done, clk_i, rst_ni, state_q == StLoad, s_tready_o, "load stuck")
endmodule

/* tb/tb_periodic_k_nearest_neighbors.sv */
`timescale 1ns / 1ps
// Self-checking bench for the periodic neighbor search. A driver pushes load and
// query transactions from a queue, a predictor written in this file works out the
// twelve ranked neighbors of every accepted query, and a monitor compares each
// output transaction against the oldest pending prediction.
module tb_periodic_k_nearest_neighbors;
  import pknn_pkg::*;

  typedef struct {
    logic        op;
    logic [9:0]  idx;
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
  } pos_item_t;

  typedef struct {
    logic [3:0]  slot;
    logic [9:0]  neighbor;
    logic [45:0] dist_sq;
    logic        found;
    logic        last;
  } nbr_t;

  localparam longint unsigned DistMax = (64'd1 << 46) - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [45:0] cfg_data_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [87:0] s_tdata_i = '0;
  logic        s_tuser_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [63:0] m_tdata_o;
  logic        m_tlast_o;

  periodic_k_nearest_neighbors dut (.*);

  always #6 clk_i = ~clk_i;

  // Pending stimulus, the transaction on the bus and the predicted neighbor lists.
  pos_item_t pending_items[$];
  pos_item_t on_bus;
  nbr_t      neighbor_queue[$];
  int        send_idle_pct = 31;
  int        recv_idle_pct = 48;
  int        mismatches = 0;

  // Mirror of the block's registers and coordinate memories.
  logic [10:0] m_count = 11'd1024;
  longint      m_half_x = 40960, m_half_y = 40960, m_half_z = 40960;
  longint unsigned m_cutoff = 64'd164433494016;
  longint      px_mem[MaxParticles];
  longint      py_mem[MaxParticles];
  longint      pz_mem[MaxParticles];

  function automatic longint clamp_coord(logic [23:0] raw, longint h);
    longint p;
    p = longint'($signed(raw));
    if (p > h) return h;
    if (p < -h) return -h;
    return p;
  endfunction

  // Minimum-image square along one axis; only a single wrap is applied.
  function automatic longint unsigned wrapped_square(longint a, longint b, longint h);
    longint d;
    d = b - a;
    if (d > h) d = d - 2 * h;
    else if (d < -h) d = d + 2 * h;
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  task automatic predict_neighbors(input pos_item_t it);
    int              who;
    int              cnt;
    int              fill;
    longint unsigned sq_sum;
    longint unsigned best_d[Neighbors];
    int              best_i[Neighbors];
    nbr_t            r;
    who = int'(it.idx);
    if (it.op == OpLoad) begin
      px_mem[who] = clamp_coord(it.px, m_half_x);
      py_mem[who] = clamp_coord(it.py, m_half_y);
      pz_mem[who] = clamp_coord(it.pz, m_half_z);
    end else begin
      for (int k = 0; k < Neighbors; k++) begin
        best_d[k] = m_cutoff;
        best_i[k] = 0;
      end
      fill = 0;
      cnt = (m_count > MaxParticles) ? MaxParticles : int'(m_count);
      for (int j = 0; j < cnt; j++) begin
        if (j != who) begin
          sq_sum = wrapped_square(px_mem[who], px_mem[j], m_half_x)
                 + wrapped_square(py_mem[who], py_mem[j], m_half_y)
                 + wrapped_square(pz_mem[who], pz_mem[j], m_half_z);
          if (sq_sum > DistMax) sq_sum = DistMax;
          // Strict compare: on a tie the earlier particle keeps its rank.
          for (int k = 0; k < Neighbors; k++) begin
            if (sq_sum < best_d[k]) begin
              for (int l = Neighbors - 1; l > k; l--) begin
                best_d[l] = best_d[l - 1];
                best_i[l] = best_i[l - 1];
              end
              best_d[k] = sq_sum;
              best_i[k] = j;
              if (fill < Neighbors) fill++;
              break;
            end
          end
        end
      end
      for (int k = 0; k < Neighbors; k++) begin
        r.slot = 4'(k);
        r.found = (k < fill);
        r.neighbor = r.found ? 10'(best_i[k]) : 10'd0;
        r.dist_sq = r.found ? 46'(best_d[k]) : 46'(m_cutoff);
        r.last = (k == Neighbors - 1);
        neighbor_queue.push_back(r);
      end
    end
  endtask

  // Driver: a transaction that is not yet accepted is held on the bus.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) predict_neighbors(on_bus);
      if (!(s_tvalid_i && !s_tready_o)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          s_tvalid_i <= 1'b1;
          s_tuser_i  <= on_bus.op;
          s_tdata_i  <= {6'd0, on_bus.pz, on_bus.py, on_bus.px, on_bus.idx};
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: each output transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    nbr_t e;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        if (neighbor_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata_o);
        end else begin
          e = neighbor_queue.pop_front();
          if (m_tdata_o[3:0] !== e.slot || m_tdata_o[13:4] !== e.neighbor ||
              m_tdata_o[59:14] !== e.dist_sq || m_tdata_o[60] !== e.found ||
              m_tdata_o[63:61] !== 3'd0 || m_tlast_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp slot %0d nbr %0d dist %0d found %0b last %0b",
                       e.slot, e.neighbor, e.dist_sq, e.found, e.last);
              $display("          got slot %0d nbr %0d dist %0d found %0b last %0b",
                       m_tdata_o[3:0], m_tdata_o[13:4], m_tdata_o[59:14],
                       m_tdata_o[60], m_tlast_o);
            end
          end
        end
      end
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [23:0] rand_pos();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(120000)) - 60000);
    endcase
  endfunction

  function automatic pos_item_t load_item(int idx, logic [23:0] x, logic [23:0] y,
                                          logic [23:0] z);
    pos_item_t it;
    it.op = OpLoad;
    it.idx = 10'(idx);
    it.px = x;
    it.py = y;
    it.pz = z;
    return it;
  endfunction

  function automatic pos_item_t query_item(int idx);
    pos_item_t it;
    it.op = OpQuery;
    it.idx = 10'(idx);
    it.px = 24'($urandom);
    it.py = 24'($urandom);
    it.pz = 24'($urandom);
    return it;
  endfunction

  // Wait until every transaction is accepted and answered, then let a trailing
  // load finish inside the block.
  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid_i || neighbor_queue.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 46'(val);
    case (idx)
      RegCount:  m_count = 11'(val);
      RegHalfX:  m_half_x = longint'(val & 64'h7fffff);
      RegHalfY:  m_half_y = longint'(val & 64'h7fffff);
      RegHalfZ:  m_half_z = longint'(val & 64'h7fffff);
      RegCutoff: m_cutoff = val & DistMax;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint unsigned pick_half();
    case ($urandom_range(3))
      0: return 1;
      1: return 4194304;
      default: return $urandom_range(4096, 200000);
    endcase
  endfunction

  initial begin
    longint unsigned cut;
    int cnt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the low 40 slots and two high ones, so no query below can read an
    // unwritten position. Scans are limited to the low 40 slots.
    write_reg(RegCount, 40);
    for (int i = 0; i < 40; i++)
      pending_items.push_back(load_item(i, rand_pos(), rand_pos(), rand_pos()));
    pending_items.push_back(load_item(700, rand_pos(), rand_pos(), rand_pos()));
    pending_items.push_back(load_item(1023, rand_pos(), rand_pos(), rand_pos()));
    pending_items.push_back(query_item(0));
    pending_items.push_back(query_item(1023));
    drain();

    // A wide box and the widest cutoff with positions at both ends of the range.
    write_reg(RegHalfX, 4194304);
    write_reg(RegHalfY, 4194304);
    write_reg(RegHalfZ, 4194304);
    write_reg(RegCutoff, DistMax);
    pending_items.push_back(load_item(5, 24'h800000, 24'h800000, 24'h800000));
    pending_items.push_back(load_item(6, 24'h7fffff, 24'h7fffff, 24'h7fffff));
    pending_items.push_back(query_item(5));
    drain();

    // Small set: duplicated positions for ties, a queried index above the count,
    // and fewer candidates than slots so some slots stay empty.
    write_reg(RegCount, 2);
    write_reg(RegHalfX, 40960);
    write_reg(RegHalfY, 40960);
    write_reg(RegHalfZ, 40960);
    write_reg(RegCutoff, 164433494016);
    pending_items.push_back(query_item(0));
    pending_items.push_back(query_item(1023));
    drain();
    write_reg(RegCount, 10);
    for (int i = 0; i < 4; i++)
      pending_items.push_back(load_item(i, 24'd4096, 24'd4096, 24'd4096));
    pending_items.push_back(load_item(4, 24'h800000, 24'h7fffff, 24'd0));
    pending_items.push_back(query_item(4));
    pending_items.push_back(query_item(2));
    pending_items.push_back(query_item(700));
    drain();

    // Zero cutoff admits no neighbor; a half-length of one clamps hard.
    write_reg(RegCutoff, 0);
    pending_items.push_back(query_item(3));
    drain();
    write_reg(RegHalfX, 1);
    write_reg(RegHalfY, 0);
    write_reg(RegCutoff, DistMax);
    pending_items.push_back(load_item(7, 24'h7fffff, 24'h800000, 24'd123));
    pending_items.push_back(query_item(7));
    drain();

    // Random chunks: idling pattern moves from sender-light to receiver-light
    // to none, and every chunk runs under fresh register settings.
    for (int chunk = 0; chunk < 6; chunk++) begin
      send_idle_pct = (chunk < 2) ? 31 : (chunk < 4) ? 48 : 0;
      recv_idle_pct = (chunk < 2) ? 48 : (chunk < 4) ? 31 : 0;
      cnt = $urandom_range(2, 24);
      write_reg(RegCount, cnt);
      write_reg(RegHalfX, pick_half());
      write_reg(RegHalfY, pick_half());
      write_reg(RegHalfZ, pick_half());
      case ($urandom_range(2))
        0: cut = DistMax;
        1: cut = 64'd164433494016;
        default: cut = {$urandom, $urandom} & DistMax;
      endcase
      write_reg(RegCutoff, cut);
      for (int n = 0; n < 45; n++) begin
        if ($urandom_range(1))
          pending_items.push_back(load_item($urandom_range(cnt + 2),
                                            rand_pos(), rand_pos(), rand_pos()));
        else if ($urandom_range(7) == 0)
          pending_items.push_back(query_item(($urandom_range(1) != 0) ? 1023 : 700));
        else
          pending_items.push_back(query_item($urandom_range(cnt - 1)));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
